FILE: hw/rtl/ddls_pkg.sv
// Shared constants and types for the dashed DDA line stepper.
// Used by ddls_divider, dashed_dda_line_stepper and ddls_checker; no dependencies.
package ddls_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int GAP_LEN_DEF    = 5;

  // Dash register and counter widths
  localparam int DASH_ON_BITS = 6;
  localparam int DASH_BITS    = 7;
  localparam logic [DASH_ON_BITS-1:0] DASH_ON_RESET = 6'd4;

  // Command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIVX = 3'b010,
    S_DIVY = 3'b100
  } ddls_state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ddls_div_stat_t;

endpackage

FILE: hw/rtl/ddls_divider.sv
// Shared restoring divider: quotient = (dividend << FRAC_BITS) / divisor.
// One quotient bit per cycle; status as ddls_pkg::ddls_div_stat_t.
module ddls_divider #(
  parameter int COORD_BITS = ddls_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ddls_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [COORD_BITS-1:0]           dividend,
  input  logic [COORD_BITS-1:0]           divisor,
  output logic [COORD_BITS+FRAC_BITS-1:0] quotient,
  output ddls_pkg::ddls_div_stat_t        stat
);

  localparam int W  = COORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]          dvd;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] dsr;
  logic [W-1:0]          quo;
  logic [CW-1:0]         cnt;
  logic                  done;

  logic [COORD_BITS:0]   trial;
  logic                  fits;
  logic [COORD_BITS:0]   diff;

  // Trial subtract of the partial remainder
  always_comb begin
    trial = {rem, dvd[W-1]};
    fits  = (trial >= {1'b0, dsr});
    diff  = trial - {1'b0, dsr};
  end

  // Control: iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (go) begin
      cnt  <= CW'(W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= {dividend, {FRAC_BITS{1'b0}}};
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[W-2:0], 1'b0};
      rem <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

FILE: hw/rtl/dashed_dda_line_stepper.sv
// Dashed DDA line stepper: top level with sequencer, accumulators and output register.
// Depends on ddls_pkg and ddls_divider.
//
// A start item (cmd=0) returns the start pixel in the next cycle, then keeps in_stall
// high while the shared divider forms the x and then the y increment, one quotient bit
// per cycle; a zero-length line starts no division. Advance items (cmd=1) stream pixels
// at one per cycle while out_stall is low. Each result is held in an output register; a
// new item is taken while a result waits only if that result is being taken in the same
// cycle. dash_on may be written at any time through the cfg channel, which is always
// ready.
module dashed_dda_line_stepper #(
  parameter int COORD_BITS = ddls_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ddls_pkg::FRAC_BITS_DEF,
  parameter int GAP_LEN    = ddls_pkg::GAP_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddls_pkg::DASH_ON_BITS-1:0] cfg_data,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic [COORD_BITS-1:0]             x_start,
  input  logic [COORD_BITS-1:0]             y_start,
  input  logic [COORD_BITS-1:0]             x_end,
  input  logic [COORD_BITS-1:0]             y_end,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [COORD_BITS-1:0]             px,
  output logic [COORD_BITS-1:0]             py,
  output logic                              plot,
  output logic                              last
);

  localparam int ACC = COORD_BITS + FRAC_BITS + 1;
  localparam int QW  = COORD_BITS + FRAC_BITS;
  localparam int DB  = ddls_pkg::DASH_BITS;
  localparam int OB  = ddls_pkg::DASH_ON_BITS;
  localparam logic [DB-1:0]  GAP_W = DB'(GAP_LEN);
  localparam logic [ACC-1:0] HALF  = ACC'(1) << (FRAC_BITS - 1);

  // State
  ddls_pkg::ddls_state_t state;
  logic [OB-1:0]         dash_on;
  logic [ACC-1:0]        x_accum;
  logic [ACC-1:0]        y_accum;
  logic [ACC-1:0]        x_step_inc;
  logic [ACC-1:0]        y_step_inc;
  logic [COORD_BITS:0]   steps_left;
  logic [DB-1:0]         dash_count;
  logic                  line_active;
  logic                  x_neg;
  logic                  y_neg;
  logic [COORD_BITS-1:0] ady_hold;

  // Handshake
  logic in_acc;
  logic start_acc;
  logic adv_acc;
  logic slot_free;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !((state == ddls_pkg::S_IDLE) && slot_free);
  assign in_acc    = in_valid && !in_stall;
  assign start_acc = in_acc && (cmd == ddls_pkg::CMD_START);
  assign adv_acc   = in_acc && (cmd == ddls_pkg::CMD_ADVANCE);

  // Endpoint geometry of a start item
  logic                  xs_neg;
  logic                  ys_neg;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic [COORD_BITS-1:0] n_len;

  always_comb begin
    xs_neg = (x_end < x_start);
    ys_neg = (y_end < y_start);
    adx    = xs_neg ? (x_start - x_end) : (x_end - x_start);
    ady    = ys_neg ? (y_start - y_end) : (y_end - y_start);
    n_len  = (adx > ady) ? adx : ady;
  end

  // Shared divider: x increment first, then y
  logic                     div_go;
  logic [COORD_BITS-1:0]    div_dividend;
  logic [COORD_BITS-1:0]    div_divisor;
  logic [QW-1:0]            div_q;
  ddls_pkg::ddls_div_stat_t div_stat;
  logic [ACC-1:0]           q_mag;
  logic [ACC-1:0]           q_signed;

  always_comb begin
    div_go       = 1'b0;
    div_dividend = ady_hold;
    div_divisor  = steps_left[COORD_BITS-1:0];
    if (state == ddls_pkg::S_IDLE) begin
      div_go       = start_acc && (n_len != '0);
      div_dividend = adx;
      div_divisor  = n_len;
    end else if (state == ddls_pkg::S_DIVX) begin
      div_go = div_stat.done;
    end
    q_mag    = ACC'(div_q);
    q_signed = ((state == ddls_pkg::S_DIVX) ? x_neg : y_neg) ? (ACC'(0) - q_mag) : q_mag;
  end

  ddls_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Step datapath: accumulate and round half up
  logic [ACC-1:0]        x_accum_next;
  logic [ACC-1:0]        y_accum_next;
  logic [ACC-1:0]        x_round;
  logic [ACC-1:0]        y_round;
  logic [COORD_BITS:0]   steps_left_next;
  logic [DB-1:0]         lim_gap;
  logic                  drawn;
  logic [DB-1:0]         dash_count_next;

  always_comb begin
    x_accum_next    = x_accum + x_step_inc;
    y_accum_next    = y_accum + y_step_inc;
    x_round         = x_accum_next + HALF;
    y_round         = y_accum_next + HALF;
    steps_left_next = steps_left - 1'b1;
    lim_gap         = DB'(dash_on) + GAP_W;
    // Dash phase: gap between dash_on and lim_gap, wrap at lim_gap
    if ((dash_count > DB'(dash_on)) && (dash_count < lim_gap)) begin
      drawn           = 1'b0;
      dash_count_next = dash_count + 1'b1;
    end else if (dash_count == lim_gap) begin
      drawn           = 1'b0;
      dash_count_next = '0;
    end else begin
      drawn           = 1'b1;
      dash_count_next = dash_count + 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddls_pkg::S_IDLE;
    end else begin
      case (state)
        ddls_pkg::S_IDLE: begin
          if (div_go) state <= ddls_pkg::S_DIVX;
        end
        ddls_pkg::S_DIVX: begin
          if (div_stat.done) state <= ddls_pkg::S_DIVY;
        end
        ddls_pkg::S_DIVY: begin
          if (div_stat.done) state <= ddls_pkg::S_IDLE;
        end
        default: state <= ddls_pkg::S_IDLE;
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dash_on <= ddls_pkg::DASH_ON_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dash_on <= cfg_data;
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum     <= '0;
      y_accum     <= '0;
      x_step_inc  <= '0;
      y_step_inc  <= '0;
      steps_left  <= '0;
      dash_count  <= '0;
      line_active <= 1'b0;
    end else if (start_acc) begin
      x_accum     <= {1'b0, x_start, {FRAC_BITS{1'b0}}};
      y_accum     <= {1'b0, y_start, {FRAC_BITS{1'b0}}};
      x_step_inc  <= '0;
      y_step_inc  <= '0;
      steps_left  <= {1'b0, n_len};
      dash_count  <= '0;
      line_active <= (n_len != '0);
    end else if (adv_acc && line_active) begin
      x_accum     <= x_accum_next;
      y_accum     <= y_accum_next;
      steps_left  <= steps_left_next;
      dash_count  <= dash_count_next;
      line_active <= (steps_left_next != '0);
    end else if (div_stat.done) begin
      if (state == ddls_pkg::S_DIVX) x_step_inc <= q_signed;
      if (state == ddls_pkg::S_DIVY) y_step_inc <= q_signed;
    end
  end

  // Signs and y distance kept for the second division
  always_ff @(posedge clk) begin
    if (start_acc) begin
      x_neg    <= xs_neg;
      y_neg    <= ys_neg;
      ady_hold <= ady;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) begin
      px   <= x_start;
      py   <= y_start;
      plot <= 1'b1;
      last <= (n_len == '0);
    end else if (adv_acc) begin
      if (line_active) begin
        px   <= x_round[FRAC_BITS +: COORD_BITS];
        py   <= y_round[FRAC_BITS +: COORD_BITS];
        plot <= drawn;
        last <= (steps_left_next == '0);
      end else begin
        px   <= '0;
        py   <= '0;
        plot <= 1'b0;
        last <= 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/ddls_checker.sv
// Port-level checks for dashed_dda_line_stepper, with the bind that attaches them.
// Depends on ddls_pkg.
module ddls_checker #(
  parameter int COORD_BITS = ddls_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  cmd,
  input logic [COORD_BITS-1:0] x_start,
  input logic [COORD_BITS-1:0] y_start,
  input logic [COORD_BITS-1:0] x_end,
  input logic [COORD_BITS-1:0] y_end,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] px,
  input logic [COORD_BITS-1:0] py,
  input logic                  plot,
  input logic                  last
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // A start item returns its start pixel, drawn, in the next cycle
  a_start_pixel: assert property (@(posedge clk) disable iff (rst)
    in_acc && (cmd == ddls_pkg::CMD_START) |=>
      out_valid && plot && (px == $past(x_start)) && (py == $past(y_start)))
    else $error("start pixel mismatch");

  // A zero-length line ends at its start pixel
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    in_acc && (cmd == ddls_pkg::CMD_START) && (x_start == x_end) && (y_start == y_end)
      |=> last)
    else $error("zero-length line not marked last");

  // Every accepted item yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("no result after accepted item");

  // A held result is never overwritten by a new item
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("item accepted while result stalled");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(px) && $stable(py) && $stable(plot) && $stable(last))
    else $error("stalled result changed");

endmodule

bind dashed_dda_line_stepper ddls_checker #(
  .COORD_BITS (COORD_BITS)
) u_ddls_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .x_start   (x_start),
  .y_start   (y_start),
  .x_end     (x_end),
  .y_end     (y_end),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .px        (px),
  .py        (py),
  .plot      (plot),
  .last      (last)
);
